@@ hdl/rle_pkg.sv @@
`timescale 1ns / 1ps

package rle_pkg;

    // run cap, clamped to the range a single ASCII digit can show
    localparam int MaxRun = 9;
    localparam int RunCapInt = (MaxRun < 1) ? 1 : ((MaxRun > 9) ? 9 : MaxRun);
    localparam logic [3:0] RUN_CAP = 4'(RunCapInt);

    localparam logic [5:0] DIGIT_BASE = 6'd48;   // ASCII '0'
    localparam logic [5:0] DIGIT_MIN  = 6'd49;
    localparam logic [5:0] DIGIT_MAX  = 6'd57;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // work for the back end: an optional closed run, then an optional flush
    typedef struct packed {
        logic       close_valid;
        logic [3:0] close_count;
        logic [7:0] close_symbol;
        logic       flush_valid;
        logic [3:0] flush_count;
        logic [7:0] flush_symbol;
    } pair_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ hdl/rle_front.sv @@
`timescale 1ns / 1ps

module rle_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_end_of_text,
    input  rle_pkg::q_status_t  q_status,
    output logic                q_push,
    output rle_pkg::pair_cmd_t  q_cmd
);

    logic [7:0] held_symbol_reg, held_symbol_next;
    logic [3:0] held_count_reg,  held_count_next;
    logic       accept;
    logic       close_run;
    logic [3:0] open_count;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        close_run  = 1'b0;
        open_count = 4'd1;
        if (held_count_reg != 4'd0) begin
            if ((s_in_byte != held_symbol_reg) || (held_count_reg >= rle_pkg::RUN_CAP)) begin
                close_run = 1'b1;
            end else begin
                open_count = held_count_reg + 4'd1;
            end
        end

        q_cmd.close_valid  = close_run;
        q_cmd.close_count  = held_count_reg;
        q_cmd.close_symbol = held_symbol_reg;
        q_cmd.flush_valid  = s_end_of_text;
        q_cmd.flush_count  = open_count;
        q_cmd.flush_symbol = s_in_byte;

        q_push = accept && (close_run || s_end_of_text);

        held_symbol_next = held_symbol_reg;
        held_count_next  = held_count_reg;
        if (accept) begin
            held_symbol_next = s_in_byte;
            held_count_next  = s_end_of_text ? 4'd0 : open_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_symbol_reg <= 8'd0;
            held_count_reg  <= 4'd0;
        end else begin
            held_symbol_reg <= held_symbol_next;
            held_count_reg  <= held_count_next;
        end
    end

    a_count_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= rle_pkg::RUN_CAP)
        else $error("open run longer than cap");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_text) |=> (held_count_reg == 4'd0))
        else $error("run left open after end of text");

    a_push_has_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_cmd.close_valid || q_cmd.flush_valid))
        else $error("empty request queued");

endmodule

@@ hdl/rle_fifo.sv @@
`timescale 1ns / 1ps

module rle_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rle_pkg::pair_cmd_t  push_cmd,
    input  logic                pop,
    output rle_pkg::pair_cmd_t  head_cmd,
    output rle_pkg::q_status_t  status
);

    rle_pkg::pair_cmd_t mem [rle_pkg::QDepth];

    logic [rle_pkg::QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rle_pkg::QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rle_pkg::QCntW-1:0] count_reg,  count_next;
    logic                      do_push, do_pop;

    assign status.full  = (count_reg == rle_pkg::QCntW'(rle_pkg::QDepth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("request pushed into full queue");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[rle_pkg::QPtrW-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

@@ hdl/rle_back.sv @@
`timescale 1ns / 1ps

module rle_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  rle_pkg::pair_cmd_t  head_cmd,
    input  rle_pkg::q_status_t  q_status,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_count_digit,
    output logic [7:0]          m_run_symbol,
    output logic                m_last_of_item,
    output logic                m_end_of_output
);

    // set once the closed-run pair of a head request that also holds a flush has gone out
    logic phase_reg, phase_next;
    logic send_close;
    logic [3:0] cur_count;
    logic taken;

    assign m_valid = !q_status.empty;
    assign taken   = m_valid && m_ready;

    always_comb begin
        send_close = head_cmd.close_valid && !phase_reg;
        if (send_close) begin
            cur_count       = head_cmd.close_count;
            m_run_symbol    = head_cmd.close_symbol;
            m_last_of_item  = !head_cmd.flush_valid;
            m_end_of_output = 1'b0;
        end else begin
            cur_count       = head_cmd.flush_count;
            m_run_symbol    = head_cmd.flush_symbol;
            m_last_of_item  = 1'b1;
            m_end_of_output = 1'b1;
        end
        m_count_digit = rle_pkg::DIGIT_BASE + {2'b00, cur_count};

        q_pop      = 1'b0;
        phase_next = phase_reg;
        if (taken) begin
            if (send_close && head_cmd.flush_valid) begin
                phase_next = 1'b1;
            end else begin
                q_pop      = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    a_phase_needs_both: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (!q_status.empty && head_cmd.close_valid && head_cmd.flush_valid))
        else $error("second half pending without a two-pair request");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_count_digit >= rle_pkg::DIGIT_MIN && m_count_digit <= rle_pkg::DIGIT_MAX))
        else $error("count digit out of range");

endmodule

@@ hdl/rle_encode_capped_run_top.sv @@
`timescale 1ns / 1ps

// Run-length encoder with runs capped at nine bytes. Bytes enter on the s_ channel,
// one per cycle while the queue has room; each closed run leaves on the m_ channel
// as an ASCII count digit ('1'..'9') and the symbol. A byte flagged end_of_text
// flushes the open run, so one byte can yield two pairs; last_of_item marks the final
// pair of a byte and end_of_output the flush pair. The front end tracks the run for
// each byte and queues pair requests in a four-entry queue; the back end drives one
// pair per cycle while m_ready is high, straight from the queue head. A byte that
// closes a run and ends the text sends both pairs from one queue entry. s_ready drops
// only when the queue is full.
module rle_encode_capped_run_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_count_digit,
    output logic [7:0] m_run_symbol,
    output logic       m_last_of_item,
    output logic       m_end_of_output
);

    rle_pkg::pair_cmd_t push_cmd;
    rle_pkg::pair_cmd_t head_cmd;
    rle_pkg::q_status_t q_status;
    logic               q_push;
    logic               q_pop;

    rle_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    rle_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    rle_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_cmd        (head_cmd),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_count_digit   (m_count_digit),
        .m_run_symbol    (m_run_symbol),
        .m_last_of_item  (m_last_of_item),
        .m_end_of_output (m_end_of_output)
    );

endmodule
